[hw/rtl/gaussian_dxdz_evaluator_assert.svh]
// ----------------------------------------------------------------------------
// gaussian dxdz evaluator assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_DXDZ_EVALUATOR_ASSERT_SVH
`define GAUSSIAN_DXDZ_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define GDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define GDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/gde_pkg.sv]
// ----------------------------------------------------------------------------
// gde_pkg
// shared widths, register codes, exp table and control types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gde_pkg;

	localparam int COORD_WIDTH     = 32;
	localparam int FRAC_BITS       = 16;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int NUM_AXES        = 3;

	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_Z = 2;

	// register codes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_X  = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Y  = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Z  = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INV_VAR_X = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INV_VAR_Y = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INV_VAR_Z = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_NORM      = 3'd6;

	localparam logic [COORD_WIDTH-1:0] ONE_Q16 = 32'h0001_0000;

	// exponent argument: each term clips at 32.0
	localparam int TERM_W = 22;
	localparam logic [TERM_W-1:0] TERM_CAP = 22'h20_0000;

	// exp unit
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam int V_W    = 22;
	localparam int N_W    = 6;
	localparam int MANT_W = 17;
	localparam int E_W    = 31;

	typedef logic [MANT_W-1:0] mant_t;

	// load strobes for the exp unit stages
	typedef struct packed {
		logic ld_s6;
		logic ld_s7;
		logic ld_s8;
	} exp_ctl_t;

	// 2^-(k/16) in Q16, k = 0..16
	function automatic mant_t pow2_entry(input logic [4:0] idx);
		mant_t r;
		case (idx)
			5'd0:    r = 17'd65536;
			5'd1:    r = 17'd62758;
			5'd2:    r = 17'd60097;
			5'd3:    r = 17'd57549;
			5'd4:    r = 17'd55109;
			5'd5:    r = 17'd52773;
			5'd6:    r = 17'd50535;
			5'd7:    r = 17'd48393;
			5'd8:    r = 17'd46341;
			5'd9:    r = 17'd44376;
			5'd10:   r = 17'd42495;
			5'd11:   r = 17'd40693;
			5'd12:   r = 17'd38968;
			5'd13:   r = 17'd37316;
			5'd14:   r = 17'd35734;
			5'd15:   r = 17'd34219;
			default: r = 17'd32768;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/gde_exp.sv]
// ----------------------------------------------------------------------------
// gde_exp
// three-stage exp(-u) unit: base-2 scaling, table interpolation, shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gde_exp import gde_pkg::*; (
	input  wire logic              clk,
	input  wire exp_ctl_t          ctl,
	input  wire logic [TERM_W-1:0] u,
	output logic      [E_W-1:0]    e
);

	logic [37:0]      v_prod;
	logic [V_W-1:0]   v_s6;
	logic             zero_s6;

	logic [4:0]       k_idx;
	logic [11:0]      w_frac;
	mant_t            t_hi;
	mant_t            t_lo;
	mant_t            t_diff;
	logic [28:0]      interp;
	mant_t            mant_c;
	mant_t            mant_s7;
	logic [N_W-1:0]   n_s7;
	logic             zero_s7;

	logic [E_W-1:0]   e_s8;

	// u * log2(e), u known below 32.0 when it matters
	assign v_prod = 38'(u[TERM_W-2:0]) * 38'(LOG2E_Q16);

	always_comb begin
		k_idx  = {1'b0, v_s6[15:12]};
		w_frac = v_s6[11:0];
		t_hi   = pow2_entry(k_idx);
		t_lo   = pow2_entry(k_idx + 5'd1);
		t_diff = t_hi - t_lo;
		interp = 29'(t_diff) * 29'(w_frac);
		mant_c = t_hi - interp[28:12];
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s6) begin
			v_s6    <= v_prod[37:16];
			zero_s6 <= u[TERM_W-1];
		end
		if (ctl.ld_s7) begin
			mant_s7 <= mant_c;
			n_s7    <= v_s6[V_W-1:FRAC_BITS];
			zero_s7 <= zero_s6;
		end
		if (ctl.ld_s8) begin
			e_s8 <= zero_s7 ? '0 : ({mant_s7, 14'b0} >> n_s7);
		end
	end

	assign e = e_s8;

endmodule

`default_nettype wire

[hw/rtl/gaussian_dxdz_evaluator.sv]
// ----------------------------------------------------------------------------
// gaussian dxdz evaluator: d2/dxdz of an anisotropic 3d gaussian, q16.16
// an accepted input item passes through stages s1..s11; s11 is the output register
// throughput: one item per cycle while out_ready does not stall the output; set by the 11-stage multiplier pipeline
// each stage holds while it is full and the next cannot move, so bubbles close up under stall
// reset: arst_n clears all valid bits; centers to 0, inverse variances and
//   norm to 1.0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gaussian_dxdz_evaluator_assert.svh"

module gaussian_dxdz_evaluator import gde_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  wire logic [COORD_WIDTH-1:0]        cfg_data,

	// input items
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] px,
	input  wire logic signed [COORD_WIDTH-1:0] py,
	input  wire logic signed [COORD_WIDTH-1:0] pz,

	// result items
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      value,
	output logic                               saturated
);

	// stage map
	//   s1  offsets from center, magnitudes and signs
	//   s2  squared offsets, fx and fz
	//   s3  partial products of the exponent terms and of fx*fz
	//   s4  clipped exponent terms, h = fx*fz/2^16
	//   s5  u = half the sum of the terms
	//   s6..s8  exp unit
	//   s9  g = |norm| * exp(-u)
	//   s10 partial products of h*g
	//   s11 final magnitude, saturation, sign (output register)
	localparam int NUM_STAGES = 11;
	localparam int S_U        = 5;
	localparam int DIFF_W     = COORD_WIDTH + 1;
	localparam int SQ_W       = 2 * COORD_WIDTH - FRAC_BITS;

	localparam logic [COORD_WIDTH-1:0] VALUE_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] VALUE_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// fields that ride along while the exponent is worked out
	typedef struct packed {
		logic [SQ_W-1:0] h;
		logic            hovf;
		logic            sx;
		logic            sz;
	} side_t;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] center_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] inv_var_q;
	logic [COORD_WIDTH-1:0]               norm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q  <= '0;
			inv_var_q <= {NUM_AXES{ONE_Q16}};
			norm_q    <= ONE_Q16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:  center_q[AXIS_X]  <= cfg_data;
				REG_CENTER_Y:  center_q[AXIS_Y]  <= cfg_data;
				REG_CENTER_Z:  center_q[AXIS_Z]  <= cfg_data;
				REG_INV_VAR_X: inv_var_q[AXIS_X] <= cfg_data;
				REG_INV_VAR_Y: inv_var_q[AXIS_Y] <= cfg_data;
				REG_INV_VAR_Z: inv_var_q[AXIS_Z] <= cfg_data;
				REG_NORM:      norm_q            <= cfg_data;
				default:       ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline flow control: a stage takes a new item when it is empty
	// or when the stage after it moves on
	// ------------------------------------------------------------------
	logic [NUM_STAGES:1] valid_q;
	logic [NUM_STAGES:1] stage_en;
	logic [NUM_STAGES:1] ld;
	logic [NUM_STAGES:0] vin;

	assign vin = {valid_q, in_valid};

	always_comb begin
		stage_en[NUM_STAGES] = ~valid_q[NUM_STAGES] | out_ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			stage_en[k] = ~valid_q[k] | stage_en[k+1];
		end
		for (int k = 1; k <= NUM_STAGES; k++) begin
			ld[k] = stage_en[k] & vin[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (stage_en[k]) begin
					valid_q[k] <= vin[k-1];
				end
			end
		end
	end

	assign in_ready  = stage_en[1];
	assign out_valid = valid_q[NUM_STAGES];

	// ------------------------------------------------------------------
	// s1: offsets from the center, exact in 33 bits, then magnitude
	// ------------------------------------------------------------------
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] p_in;
	logic [NUM_AXES-1:0][DIFF_W-1:0]      diff_c;
	logic [NUM_AXES-1:0][DIFF_W-1:0]      diff_neg_c;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] a_c;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] a_s1;
	logic                                 sx_s1, sz_s1;

	assign p_in = {pz, py, px};

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			diff_c[i]     = {p_in[i][COORD_WIDTH-1], p_in[i]}
			              - {center_q[i][COORD_WIDTH-1], center_q[i]};
			diff_neg_c[i] = DIFF_W'(0) - diff_c[i];
			// |offset| never exceeds 2^32 - 1
			a_c[i]        = diff_c[i][DIFF_W-1] ? diff_neg_c[i][COORD_WIDTH-1:0]
			                                    : diff_c[i][COORD_WIDTH-1:0];
		end
	end

	// ------------------------------------------------------------------
	// s2: squares and the two slope factors, one 32x32 multiply each
	// ------------------------------------------------------------------
	logic [NUM_AXES-1:0][2*COORD_WIDTH-1:0] sq_prod;
	logic [2*COORD_WIDTH-1:0]               fx_prod, fz_prod;
	logic [NUM_AXES-1:0][SQ_W-1:0]          sq_s2;
	logic [SQ_W-1:0]                        fx_s2, fz_s2;
	logic                                   sx_s2, sz_s2;

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			sq_prod[i] = 64'(a_s1[i]) * 64'(a_s1[i]);
		end
		fx_prod = 64'(a_s1[AXIS_X]) * 64'(inv_var_q[AXIS_X]);
		fz_prod = 64'(a_s1[AXIS_Z]) * 64'(inv_var_q[AXIS_Z]);
	end

	// ------------------------------------------------------------------
	// s3: partial products. a square at or above 2^37 clips its term
	// outright unless the inverse variance is zero
	// ------------------------------------------------------------------
	logic [NUM_AXES-1:0][63:0] tlo_c;
	logic [NUM_AXES-1:0][36:0] thi_c;
	logic [NUM_AXES-1:0]       tbig_c;
	logic [NUM_AXES-1:0][63:0] tlo_s3;
	logic [NUM_AXES-1:0][36:0] thi_s3;
	logic [NUM_AXES-1:0]       tbig_s3;
	logic [63:0]               pp_ll_c, pp_ll_s3;
	logic [47:0]               pp_lh_c, pp_lh_s3;
	logic [47:0]               pp_hl_c, pp_hl_s3;
	logic [31:0]               pp_hh_c, pp_hh_s3;
	logic                      sx_s3, sz_s3;

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			tlo_c[i]  = 64'(sq_s2[i][31:0]) * 64'(inv_var_q[i]);
			thi_c[i]  = 37'(sq_s2[i][36:32]) * 37'(inv_var_q[i]);
			tbig_c[i] = (|sq_s2[i][SQ_W-1:37]) & (|inv_var_q[i]);
		end
		pp_ll_c = 64'(fx_s2[31:0]) * 64'(fz_s2[31:0]);
		pp_lh_c = 48'(fx_s2[31:0]) * 48'(fz_s2[SQ_W-1:32]);
		pp_hl_c = 48'(fx_s2[SQ_W-1:32]) * 48'(fz_s2[31:0]);
		pp_hh_c = 32'(fx_s2[SQ_W-1:32]) * 32'(fz_s2[SQ_W-1:32]);
	end

	// ------------------------------------------------------------------
	// s4: assemble terms and h. h at or above 2^48 forces saturation
	// whenever g is nonzero, so only the flag is kept then
	// ------------------------------------------------------------------
	logic [NUM_AXES-1:0][68:0]       tsum_c;
	logic [NUM_AXES-1:0][52:0]       tshift_c;
	logic [NUM_AXES-1:0][TERM_W-1:0] term_c;
	logic [NUM_AXES-1:0][TERM_W-1:0] term_s4;
	logic [95:0]                     ffull_c;
	side_t                           side_c;
	side_t                           side_s4;

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			tsum_c[i]   = 69'(tlo_s3[i]) + (69'(thi_s3[i]) << 32);
			tshift_c[i] = tsum_c[i][68:FRAC_BITS];
			term_c[i]   = (tbig_s3[i] || tshift_c[i] >= 53'(TERM_CAP))
			            ? TERM_CAP : tshift_c[i][TERM_W-1:0];
		end
		ffull_c = 96'(pp_ll_s3) + (96'(pp_lh_s3) << 32) + (96'(pp_hl_s3) << 32)
		        + (96'(pp_hh_s3) << 64);
		side_c.h    = ffull_c[63:FRAC_BITS];
		side_c.hovf = |ffull_c[95:64];
		side_c.sx   = sx_s3;
		side_c.sz   = sz_s3;
	end

	// ------------------------------------------------------------------
	// s5: u, then the exp unit (s6..s8)
	// ------------------------------------------------------------------
	logic [TERM_W:0]   usum_c;
	logic [TERM_W-1:0] u_s5;
	side_t             side_s5, side_s6, side_s7, side_s8;
	exp_ctl_t          exp_ctl;
	logic [E_W-1:0]    e_s8;

	assign usum_c = (TERM_W+1)'(term_s4[AXIS_X]) + (TERM_W+1)'(term_s4[AXIS_Y])
	              + (TERM_W+1)'(term_s4[AXIS_Z]);

	assign exp_ctl.ld_s6 = ld[6];
	assign exp_ctl.ld_s7 = ld[7];
	assign exp_ctl.ld_s8 = ld[8];

	gde_exp u_exp (
		.clk (clk),
		.ctl (exp_ctl),
		.u   (u_s5),
		.e   (e_s8)
	);

	// ------------------------------------------------------------------
	// s9: g = |norm| * e / 2^30, fits 32 bits since |norm| <= 2^31
	// ------------------------------------------------------------------
	logic [COORD_WIDTH-1:0] norm_mag;
	logic [62:0]            g_prod;
	logic [31:0]            g_s9;
	side_t                  side_s9;

	assign norm_mag = norm_q[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - norm_q) : norm_q;
	assign g_prod   = 63'(norm_mag) * 63'(e_s8);

	// ------------------------------------------------------------------
	// s10: partial products of h*g, sign of the result
	// ------------------------------------------------------------------
	logic [63:0] hg_lo_c, hg_lo_s10;
	logic [47:0] hg_hi_c, hg_hi_s10;
	logic        ovf_s10;
	logic        neg_s10;

	assign hg_lo_c = 64'(side_s9.h[31:0]) * 64'(g_s9);
	assign hg_hi_c = 48'(side_s9.h[SQ_W-1:32]) * 48'(g_s9);

	// ------------------------------------------------------------------
	// s11: magnitude, clip to the signed range, apply sign
	// ------------------------------------------------------------------
	logic [79:0]            mag_full_c;
	logic [63:0]            mag_c;
	logic [63:0]            lim_c;
	logic                   sat_c;
	logic [COORD_WIDTH-1:0] clip_c;
	logic [COORD_WIDTH-1:0] value_c;
	logic [COORD_WIDTH-1:0] value_s11;
	logic                   sat_s11;

	always_comb begin
		mag_full_c = 80'(hg_lo_s10) + (80'(hg_hi_s10) << 32);
		mag_c      = mag_full_c[79:FRAC_BITS];
		// negative results may reach 2^31
		lim_c      = neg_s10 ? 64'(VALUE_MIN) : 64'(VALUE_MAX);
		sat_c      = ovf_s10 | (mag_c > lim_c);
		clip_c     = sat_c ? lim_c[COORD_WIDTH-1:0] : mag_c[COORD_WIDTH-1:0];
		// negating zero leaves zero, so a zero result is never negative
		value_c    = neg_s10 ? (COORD_WIDTH'(0) - clip_c) : clip_c;
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			a_s1  <= a_c;
			sx_s1 <= diff_c[AXIS_X][DIFF_W-1];
			sz_s1 <= diff_c[AXIS_Z][DIFF_W-1];
		end
		if (ld[2]) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				sq_s2[i] <= sq_prod[i][2*COORD_WIDTH-1:FRAC_BITS];
			end
			fx_s2 <= fx_prod[2*COORD_WIDTH-1:FRAC_BITS];
			fz_s2 <= fz_prod[2*COORD_WIDTH-1:FRAC_BITS];
			sx_s2 <= sx_s1;
			sz_s2 <= sz_s1;
		end
		if (ld[3]) begin
			tlo_s3   <= tlo_c;
			thi_s3   <= thi_c;
			tbig_s3  <= tbig_c;
			pp_ll_s3 <= pp_ll_c;
			pp_lh_s3 <= pp_lh_c;
			pp_hl_s3 <= pp_hl_c;
			pp_hh_s3 <= pp_hh_c;
			sx_s3    <= sx_s2;
			sz_s3    <= sz_s2;
		end
		if (ld[4]) begin
			term_s4 <= term_c;
			side_s4 <= side_c;
		end
		if (ld[S_U]) begin
			u_s5    <= usum_c[TERM_W:1];
			side_s5 <= side_s4;
		end
		if (ld[6]) begin
			side_s6 <= side_s5;
		end
		if (ld[7]) begin
			side_s7 <= side_s6;
		end
		if (ld[8]) begin
			side_s8 <= side_s7;
		end
		if (ld[9]) begin
			g_s9    <= g_prod[61:30];
			side_s9 <= side_s8;
		end
		if (ld[10]) begin
			hg_lo_s10 <= hg_lo_c;
			hg_hi_s10 <= hg_hi_c;
			ovf_s10   <= side_s9.hovf & (|g_s9);
			neg_s10   <= side_s9.sx ^ side_s9.sz ^ norm_q[COORD_WIDTH-1];
		end
		if (ld[NUM_STAGES]) begin
			value_s11 <= value_c;
			sat_s11   <= sat_c;
		end
	end

	assign value     = value_s11;
	assign saturated = sat_s11;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// a clipped item carries one of the two range limits
	`GDE_ASSERT_IMPLIES(a_sat_at_limit, clk, arst_n, out_valid && saturated, value == VALUE_MAX || value == VALUE_MIN, "saturated item not at a range limit")
	// an open output side lets every stage move, so the input side must be open
	`GDE_ASSERT_IMPLIES(a_ready_when_drained, clk, arst_n, out_ready, in_ready, "input blocked while output is taken")
	// an item held at the exp unit input keeps its exponent argument
	`GDE_ASSERT_NEXT(a_u_holds, clk, arst_n, valid_q[S_U] && !stage_en[S_U], valid_q[S_U] && $stable(u_s5), "stalled item at exp input lost or changed")

endmodule

`default_nettype wire

[test/gaussian_dxdz_evaluator_test.sv]
// ----------------------------------------------------------------------------
// gaussian dxdz evaluator testbench
// drives 3d points through the valid/ready input, predicts each d2/dxdz
// result in q16.16 from a local copy of the registers and compares it with
// every item that leaves the block; directed corners first, then random
// points under random register settings and three idle patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_dxdz_evaluator_test;
	import gde_pkg::*;

	// cycles from an accepted point to its result
	localparam int PIPE_LATENCY   = 11;
	// cycles with no item moving on either side before the run is called hung
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

	localparam logic [31:0] Q16_MIN = 32'h8000_0000;
	localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;

	// exponent argument: each squared term clips at 32.0
	localparam logic [63:0] TERM_CEIL   = 64'h0000_0000_0020_0000;
	localparam logic [63:0] TERM_BOUND  = 64'h0000_001F_FFFF_FFFF;
	localparam logic [63:0] LOG2E_FIX   = 64'd94548;
	localparam logic [63:0] WORD_MAX_64 = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] value;
		logic        saturated;
	} dxdz_result_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                       cfg_we    = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_CENTER_X;
	logic [COORD_WIDTH-1:0]     cfg_data  = '0;

	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic signed [COORD_WIDTH-1:0] px = '0;
	logic signed [COORD_WIDTH-1:0] py = '0;
	logic signed [COORD_WIDTH-1:0] pz = '0;

	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [COORD_WIDTH-1:0] value;
	logic                          saturated;

	// register values the block holds, indexed by register code
	logic [31:0] dxdz_cfg [7];

	dxdz_result_t expected_results [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors        = 0;
	int points_sent   = 0;
	int results_seen  = 0;
	int sat_results   = 0;
	int zero_results  = 0;
	int config_loads  = 0;
	int stall_cycles  = 0;

	gaussian_dxdz_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.px        (px),
		.py        (py),
		.pz        (pz),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.saturated (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// 2^-(k/16) in q16, k = 0..16
	function automatic logic [63:0] pow2_frac(input logic [63:0] k);
		case (k)
			64'd0:   return 64'd65536;
			64'd1:   return 64'd62758;
			64'd2:   return 64'd60097;
			64'd3:   return 64'd57549;
			64'd4:   return 64'd55109;
			64'd5:   return 64'd52773;
			64'd6:   return 64'd50535;
			64'd7:   return 64'd48393;
			64'd8:   return 64'd46341;
			64'd9:   return 64'd44376;
			64'd10:  return 64'd42495;
			64'd11:  return 64'd40693;
			64'd12:  return 64'd38968;
			64'd13:  return 64'd37316;
			64'd14:  return 64'd35734;
			64'd15:  return 64'd34219;
			default: return 64'd32768;
		endcase
	endfunction

	// d^2 * inv_var in q16, clipped at 32.0
	function automatic logic [63:0] scaled_square(input logic [63:0] a, input logic [63:0] iv);
		logic [63:0] sq;
		sq = (a * a) >> FRAC_BITS;
		if (iv == 0)
			return 0;
		if (sq > TERM_BOUND / iv)
			return TERM_CEIL;
		return (sq * iv) >> FRAC_BITS;
	endfunction

	// exp(-u) as 2^-(u*log2 e): table lookup plus linear interpolation, q2.30
	function automatic logic [63:0] exp_fixed(input logic [63:0] u);
		logic [63:0] v, n, f, k, w, hi, lo, m;
		if (u >= TERM_CEIL)
			return 0;
		v  = (u * LOG2E_FIX) >> 16;
		n  = v >> FRAC_BITS;
		f  = v & 64'hFFFF;
		k  = f >> 12;
		w  = f & 64'hFFF;
		hi = pow2_frac(k);
		lo = pow2_frac(k + 1);
		m  = hi - (((hi - lo) * w) >> 12);
		if (n > 62)
			return 0;
		return (m << 14) >> n;
	endfunction

	function automatic dxdz_result_t predict_dxdz(input logic [31:0] x, y, z);
		longint signed sx, sy, sz, cx, cy, cz, dx, dy, dz, nv;
		logic [63:0] ax, ay, az, an, ivx, ivy, ivz;
		logic [63:0] u, e, g, fx, fz, h, lim, big, mag, wrapped;
		logic neg, sat;
		dxdz_result_t r;
		sx = $signed(x);
		sy = $signed(y);
		sz = $signed(z);
		cx = $signed(dxdz_cfg[REG_CENTER_X]);
		cy = $signed(dxdz_cfg[REG_CENTER_Y]);
		cz = $signed(dxdz_cfg[REG_CENTER_Z]);
		nv = $signed(dxdz_cfg[REG_NORM]);
		ivx = {32'h0, dxdz_cfg[REG_INV_VAR_X]};
		ivy = {32'h0, dxdz_cfg[REG_INV_VAR_Y]};
		ivz = {32'h0, dxdz_cfg[REG_INV_VAR_Z]};
		dx = sx - cx;
		dy = sy - cy;
		dz = sz - cz;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		az = (dz < 0) ? -dz : dz;
		an = (nv < 0) ? -nv : nv;

		u  = (scaled_square(ax, ivx) + scaled_square(ay, ivy) + scaled_square(az, ivz)) >> 1;
		e  = exp_fixed(u);
		g  = (an * e) >> 30;
		fx = (ax * ivx) >> FRAC_BITS;
		fz = (az * ivz) >> FRAC_BITS;

		// sign: odd count of negative dx, dz, norm
		neg = ((dx < 0) != (dz < 0)) != (nv < 0);
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		sat = 1'b0;
		mag = 0;
		if (fx != 0 && fz != 0 && g != 0) begin
			if (fx > WORD_MAX_64 / fz) begin
				sat = 1'b1;
			end else begin
				h   = (fx * fz) >> FRAC_BITS;
				big = ((lim + 1) << FRAC_BITS) - 1;
				if (h > big / g)
					sat = 1'b1;
				else
					mag = (h * g) >> FRAC_BITS;
			end
		end
		if (sat)
			mag = lim;
		// zero carries no sign
		if (mag == 0)
			neg = 1'b0;
		wrapped     = neg ? -mag : mag;
		r.value     = wrapped[31:0];
		r.saturated = sat;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result side: random backpressure, compare, watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_results
		dxdz_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no point pending, value %h saturated %b",
					$time, value, saturated);
				errors++;
			end else begin
				want = expected_results.pop_front();
				results_seen++;
				if (value !== want.value) begin
					$display("%0t: value mismatch, expected %h actual %h",
						$time, want.value, value);
					errors++;
				end
				if (saturated !== want.saturated) begin
					$display("%0t: saturated mismatch, expected %b actual %b",
						$time, want.saturated, saturated);
					errors++;
				end
				if (saturated === 1'b1)
					sat_results++;
				if (value === '0)
					zero_results++;
			end
		end
	end

	// counts cycles in which no item moves on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// shared drivers
	// ------------------------------------------------------------------

	// one point: random idle cycles first, then hold until accepted
	// valid stays high after acceptance so back-to-back items need no extra edge
	task automatic send_point(input logic [31:0] x, y, z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		px       <= x;
		py       <= y;
		pz       <= z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(predict_dxdz(x, y, z));
		points_sent++;
	endtask

	// stop sending and wait for every pending result
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// write every register from dxdz_cfg; optionally hit the unmapped index last
	task automatic write_regs(input bit poke_unused);
		for (int i = REG_CENTER_X; i <= REG_NORM; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_INDEX_WIDTH'(i);
			cfg_data  <= dxdz_cfg[i];
			@(posedge clk);
		end
		if (poke_unused) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_UNUSED;
			cfg_data  <= $urandom;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		config_loads++;
	endtask

	function automatic void restore_reset_config();
		dxdz_cfg[REG_CENTER_X]  = '0;
		dxdz_cfg[REG_CENTER_Y]  = '0;
		dxdz_cfg[REG_CENTER_Z]  = '0;
		dxdz_cfg[REG_INV_VAR_X] = ONE_Q16;
		dxdz_cfg[REG_INV_VAR_Y] = ONE_Q16;
		dxdz_cfg[REG_INV_VAR_Z] = ONE_Q16;
		dxdz_cfg[REG_NORM]      = ONE_Q16;
	endfunction

	// ------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------

	// registers left at their reset values, nothing written
	task automatic test_reset_config();
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_point(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
		send_point(32'hFFFF_0000, 32'h0002_0000, 32'h0001_0000);
		send_point(32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_8000);
	endtask

	// coordinate and register extremes
	task automatic test_field_extremes();
		send_point(Q16_MAX, Q16_MAX, Q16_MAX);
		send_point(Q16_MIN, Q16_MIN, Q16_MIN);
		send_point(Q16_MIN, 32'h0000_0000, Q16_MAX);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain_pipeline();
		dxdz_cfg[REG_CENTER_X]  = Q16_MAX;
		dxdz_cfg[REG_CENTER_Y]  = Q16_MIN;
		dxdz_cfg[REG_CENTER_Z]  = Q16_MIN;
		dxdz_cfg[REG_INV_VAR_X] = 32'hFFFF_FFFF;
		dxdz_cfg[REG_INV_VAR_Y] = 32'hFFFF_FFFF;
		dxdz_cfg[REG_INV_VAR_Z] = 32'hFFFF_FFFF;
		dxdz_cfg[REG_NORM]      = Q16_MIN;
		write_regs(1'b0);
		// widest offsets in both directions
		send_point(Q16_MIN, Q16_MAX, Q16_MAX);
		// one lsb off the centre: exp at 1.0, result just under full scale
		send_point(32'h7FFF_FFFE, Q16_MIN, 32'h8000_0001);
	endtask

	// exponent at and just under the 32.0 cutoff
	task automatic test_exp_cutoff();
		drain_pipeline();
		restore_reset_config();
		write_regs(1'b0);
		send_point(32'h0008_0000, 32'h0000_0000, 32'h0008_0000);
		send_point(32'h0008_0000, 32'h0008_0000, 32'h0008_0000);
		send_point(32'h0004_0000, 32'h0003_0000, 32'h0006_0000);
	endtask

	// steep variances with a full-scale norm clip in both directions
	task automatic test_saturation();
		drain_pipeline();
		restore_reset_config();
		dxdz_cfg[REG_INV_VAR_X] = 32'h0400_0000;
		dxdz_cfg[REG_INV_VAR_Z] = 32'h0400_0000;
		dxdz_cfg[REG_NORM]      = Q16_MAX;
		write_regs(1'b0);
		send_point(32'h0000_1000, 32'h0000_0000, 32'h0000_1000);
		send_point(32'hFFFF_F000, 32'h0000_0000, 32'h0000_1000);
		drain_pipeline();
		dxdz_cfg[REG_NORM] = Q16_MIN;
		write_regs(1'b0);
		send_point(32'hFFFF_F000, 32'h0000_0000, 32'h0000_1000);
		send_point(32'h0000_1000, 32'h0000_0000, 32'h0000_1000);
	endtask

	// a zero inverse variance on each axis in turn
	task automatic test_zero_inv_var();
		drain_pipeline();
		restore_reset_config();
		dxdz_cfg[REG_INV_VAR_X] = '0;
		dxdz_cfg[REG_NORM]      = 32'hFFFF_0000;
		write_regs(1'b0);
		// a product that comes out zero must carry no sign
		send_point(32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000);
		drain_pipeline();
		dxdz_cfg[REG_INV_VAR_X] = ONE_Q16;
		dxdz_cfg[REG_INV_VAR_Z] = '0;
		write_regs(1'b0);
		send_point(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
		drain_pipeline();
		dxdz_cfg[REG_INV_VAR_Z] = ONE_Q16;
		dxdz_cfg[REG_INV_VAR_Y] = '0;
		write_regs(1'b0);
		// far in y, but y adds nothing to the exponent
		send_point(32'h0001_0000, 32'h0064_0000, 32'h0001_0000);
	endtask

	// a write to the unmapped index must leave every register alone
	task automatic test_unused_index();
		drain_pipeline();
		restore_reset_config();
		write_regs(1'b1);
		send_point(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000);
		send_point(32'hFFFF_8000, 32'h0000_0000, 32'h0000_8000);
	endtask

	// ------------------------------------------------------------------
	// random tests
	// ------------------------------------------------------------------

	function automatic void randomize_config();
		logic signed [31:0] ofs;
		for (int i = REG_CENTER_X; i <= REG_NORM; i++) begin
			if (i >= REG_INV_VAR_X && i <= REG_INV_VAR_Z) begin
				case ($urandom_range(7))
					0:       dxdz_cfg[i] = '0;
					1:       dxdz_cfg[i] = 32'hFFFF_FFFF;
					2:       dxdz_cfg[i] = ONE_Q16;
					default: dxdz_cfg[i] = $urandom >> $urandom_range(8, 24);
				endcase
			end else begin
				// centres over the full range, norm mostly moderate
				if (i == REG_NORM)
					ofs = $signed($urandom) >>> $urandom_range(8, 24);
				else
					ofs = $signed($urandom) >>> $urandom_range(31);
				case ($urandom_range(7))
					0:       dxdz_cfg[i] = Q16_MIN;
					1:       dxdz_cfg[i] = Q16_MAX;
					2:       dxdz_cfg[i] = '0;
					default: dxdz_cfg[i] = ofs;
				endcase
			end
		end
	endfunction

	// mostly points near the centre so the exponent stays live,
	// some anywhere, some on the coordinate extremes
	task automatic send_random_point();
		logic [31:0] p [3];
		logic signed [31:0] ofs;
		int mode;
		mode = $urandom_range(99);
		for (int a = AXIS_X; a <= AXIS_Z; a++) begin
			ofs = $signed($urandom) >>> $urandom_range(12, 31);
			if (mode < 70) begin
				p[a] = dxdz_cfg[REG_CENTER_X + a] + ofs;
			end else if (mode < 85) begin
				p[a] = $urandom;
			end else begin
				case ($urandom_range(3))
					0:       p[a] = Q16_MIN;
					1:       p[a] = Q16_MAX;
					2:       p[a] = '0;
					default: p[a] = dxdz_cfg[REG_CENTER_X + a];
				endcase
			end
		end
		send_point(p[AXIS_X], p[AXIS_Y], p[AXIS_Z]);
	endtask

	// new register setting every 50 points, loaded only once the pipe is empty
	task automatic test_random_points(input int count, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				drain_pipeline();
				randomize_config();
				write_regs($urandom_range(1));
			end
			send_random_point();
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		restore_reset_config();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 15;
		recv_idle_pct = 88;
		test_reset_config();
		test_field_extremes();
		test_exp_cutoff();
		test_saturation();
		test_zero_inv_var();
		test_unused_index();

		test_random_points(400, 15, 88);
		test_random_points(400, 88, 15);
		test_random_points(400, 0, 0);

		// let any stray result show up before judging
		drain_pipeline();
		repeat (PIPE_LATENCY + 8) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_results.size());
			errors += expected_results.size();
		end
		$display("sent %0d points under %0d register loads, checked %0d results",
			points_sent, config_loads, results_seen);
		$display("%0d saturated and %0d zero results seen, %0d errors",
			sat_results, zero_results, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/gde_pkg.sv
hw/rtl/gde_exp.sv
hw/rtl/gaussian_dxdz_evaluator.sv
test/gaussian_dxdz_evaluator_test.sv
